[hw/rtl/sqsb_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher package
// Shared widths, codes, item and record types, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package sqsb_pkg;

    // Default batch limit in quads.
    localparam int MAX_QUADS_DEF = 8192;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;

    // Stream widths.
    localparam int IN_TDATA_W  = 280;
    localparam int OUT_TDATA_W = 168;

    // Divider operand widths: numerator magnitude and denominator.
    localparam int DIV_NUM_W = 36;
    localparam int DIV_DEN_W = 16;

    // CORDIC setup.
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_XW    = 34;
    localparam int CORDIC_ZW    = 26;
    localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Input item kinds.
    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Result record kinds.
    localparam logic REC_VERTEX = 1'b0;
    localparam logic REC_END    = 1'b1;

    // One decoded input beat.
    typedef struct packed {
        logic               kind;
        logic [15:0]        tex_id;
        logic [15:0]        tex_w;
        logic [15:0]        tex_h;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [15:0]        dest_w;
        logic [15:0]        dest_h;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic [15:0]        src_w;
        logic [15:0]        src_h;
        logic [31:0]        tint;
        logic [15:0]        rot;
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic [1:0]         flip;
        logic [15:0]        depth;
        logic               tex_zero;
    } t_item;

    // One result record.
    typedef struct packed {
        logic               rec_kind;
        logic [15:0]        vtx_num;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [19:0] tex_u;
        logic signed [19:0] tex_v;
        logic [15:0]        depth;
        logic [31:0]        color;
        logic [15:0]        btex;
        logic               last;
    } t_rec;

    // Arctangent of 2^-i, scaled to 2^21 per eighth of a turn.
    function automatic logic [22:0] sqsb_atan(input logic [4:0] idx);
        logic [22:0] val;
        case (idx)
            5'd0:    val = 23'd2097152;
            5'd1:    val = 23'd1238021;
            5'd2:    val = 23'd654128;
            5'd3:    val = 23'd332051;
            5'd4:    val = 23'd166668;
            5'd5:    val = 23'd83415;
            5'd6:    val = 23'd41718;
            5'd7:    val = 23'd20860;
            5'd8:    val = 23'd10430;
            5'd9:    val = 23'd5215;
            5'd10:   val = 23'd2608;
            5'd11:   val = 23'd1304;
            5'd12:   val = 23'd652;
            5'd13:   val = 23'd326;
            5'd14:   val = 23'd163;
            5'd15:   val = 23'd81;
            5'd16:   val = 23'd41;
            5'd17:   val = 23'd20;
            5'd18:   val = 23'd10;
            5'd19:   val = 23'd5;
            default: val = 23'd0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/sprite_quad_setup_batcher.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher
// Turns sprite draws into four corner vertices and batch-end records.
// ----------------------------------------------------------------------------
// A draw with a nonzero texture size runs six divisions on one shared
// bit-serial divider (a launch, one step per quotient bit and a store each);
// an origin division by a zero source size skips the divider and stores its
// bypass value directly. The back first takes the beat and checks the batch,
// then forms the corner offsets, and the four corners then run their products
// in turn on one multiplier; the sine and cosine run at the same time as the
// divisions. A draw that also closes its batch ends with a batch-end record.
// A flush, or a draw with a zero-size texture, skips the divisions and the
// corners. Every record also waits for its output handshake.
// The front queues two beats, so input is taken while the back works and
// while a result waits.
module sprite_quad_setup_batcher import sqsb_pkg::*; #(
    parameter int MAX_QUADS = MAX_QUADS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Draw and flush beats.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // texture_id, texture_size, dest_pos, dest_size, src_pos, src_size,
    // tint_color, rotation, origin, flip, layer_depth, six zero bits
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                   s_axis_tuser,
    // Result beats.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // vertex_number, pos_x, pos_y, tex_u, tex_v, vertex_depth, vertex_color,
    // batch_texture
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // record_kind
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast,
    // Immediate mode register.
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data
);

    logic  r_imm;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;
    t_rec  rec;

    // Immediate mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imm <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_imm <= i_cfg_wr_data;
        end
    end

    sqsb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_valid  (q_valid),
        .o_item   (q_item),
        .i_pop    (q_pop)
    );

    sqsb_back #(
        .MAX_QUADS (MAX_QUADS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_imm       (r_imm),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_rec_valid (m_axis_tvalid),
        .o_rec       (rec),
        .i_rec_ready (m_axis_tready)
    );

    // Pack the record onto the result stream.
    assign m_axis_tdata = {rec.btex, rec.color, rec.depth, rec.tex_v, rec.tex_u,
                           rec.pos_y, rec.pos_x, rec.vtx_num};
    assign m_axis_tuser = rec.rec_kind;
    assign m_axis_tlast = rec.last;

endmodule

[hw/rtl/sqsb_front.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher front
// Accepts input beats, decodes and classifies them, and queues them for the back.
// ----------------------------------------------------------------------------
module sqsb_front import sqsb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic                  i_tuser,
    output logic                  o_valid,
    output t_item                 o_item,
    input  logic                  i_pop
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_item          r_mem [QDEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    t_item          dec;
    logic           push;
    logic           pop;

    // Unpack the beat and mark a texture of zero size.
    always_comb begin
        dec.kind     = i_tuser;
        dec.tex_id   = i_tdata[15:0];
        dec.tex_w    = i_tdata[31:16];
        dec.tex_h    = i_tdata[47:32];
        dec.dest_x   = $signed(i_tdata[63:48]);
        dec.dest_y   = $signed(i_tdata[79:64]);
        dec.dest_w   = i_tdata[95:80];
        dec.dest_h   = i_tdata[111:96];
        dec.src_x    = $signed(i_tdata[127:112]);
        dec.src_y    = $signed(i_tdata[143:128]);
        dec.src_w    = i_tdata[159:144];
        dec.src_h    = i_tdata[175:160];
        dec.tint     = i_tdata[207:176];
        dec.rot      = i_tdata[223:208];
        dec.org_x    = $signed(i_tdata[239:224]);
        dec.org_y    = $signed(i_tdata[255:240]);
        dec.flip     = i_tdata[257:256];
        dec.depth    = i_tdata[273:258];
        dec.tex_zero = (i_tdata[31:16] == 16'd0) || (i_tdata[47:32] == 16'd0);
    end

    assign o_tready = (r_cnt != CW'(QDEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_mem[r_rd];
    assign push     = i_tvalid && o_tready;
    assign pop      = i_pop && o_valid;

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= dec;
        end
    end

endmodule

[hw/rtl/sqsb_div.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher divider
// Bit-serial restoring divider giving (num + den/2) / den, one bit per cycle.
// ----------------------------------------------------------------------------
module sqsb_div import sqsb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W:0]   o_quot
);

    localparam int QW = DIV_NUM_W + 1;
    localparam int CW = $clog2(QW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [QW-1:0]        r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial  = {r_rem, r_num[QW-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_num;

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the rounding bias is added up front, then one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {1'b0, i_num} + QW'(i_den >> 1);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_num <= {r_num[QW-2:0], fits};
        end
    end

endmodule

[hw/rtl/sqsb_cordic.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher CORDIC
// Iterative sine and cosine of a 16-bit angle, rounded to Q16.
// ----------------------------------------------------------------------------
module sqsb_cordic import sqsb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_busy,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin
);

    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ITER = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   r_state;
    logic [SW-1:0]                r_step;
    logic [1:0]                   r_quad;
    logic signed [CORDIC_XW-1:0]  r_x;
    logic signed [CORDIC_XW-1:0]  r_y;
    logic signed [CORDIC_ZW-1:0]  r_z;
    logic signed [17:0]           r_cos;
    logic signed [17:0]           r_sin;

    logic [15:0]                  a_off;
    logic [1:0]                   quad;
    logic [15:0]                  resid;
    logic signed [CORDIC_XW-1:0]  dx;
    logic signed [CORDIC_XW-1:0]  dy;
    logic signed [CORDIC_ZW-1:0]  at;
    logic signed [CORDIC_XW-1:0]  c_sel;
    logic signed [CORDIC_XW-1:0]  s_sel;
    logic signed [CORDIC_XW-1:0]  c_rnd;
    logic signed [CORDIC_XW-1:0]  s_rnd;

    // Fold the angle into the quadrant nearest to zero.
    assign a_off = i_angle + 16'd8192;
    assign quad  = a_off[15:14];
    assign resid = i_angle - {quad, 14'd0};

    // One micro-rotation.
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign at = $signed({3'd0, sqsb_atan(5'(r_step))});

    // Undo the fold and round to Q16.
    always_comb begin
        case (r_quad)
            2'd1:    begin c_sel = -r_y; s_sel = r_x;  end
            2'd2:    begin c_sel = -r_x; s_sel = -r_y; end
            2'd3:    begin c_sel = r_y;  s_sel = -r_x; end
            default: begin c_sel = r_x;  s_sel = r_y;  end
        endcase
        c_rnd = c_sel + 34'sd8192;
        s_rnd = s_sel + 34'sd8192;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_ITER;
                        r_step  <= '0;
                    end
                end
                ST_ITER: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Rotation datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_quad <= quad;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= {{2{resid[15]}}, resid, 8'd0};
        end else if (r_state == ST_ITER) begin
            if (!r_z[CORDIC_ZW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end else if (r_state == ST_FIN) begin
            r_cos <= $signed(c_rnd[31:14]);
            r_sin <= $signed(s_rnd[31:14]);
        end
    end

endmodule

[hw/rtl/sqsb_back.sv]
// ----------------------------------------------------------------------------
// Sprite quad setup batcher back
// Tracks the batch, runs the divisions and rotations, and emits result records.
// ----------------------------------------------------------------------------
module sqsb_back import sqsb_pkg::*; #(
    parameter int MAX_QUADS = MAX_QUADS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_imm,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    output logic  o_rec_valid,
    output t_rec  o_rec,
    input  logic  i_rec_ready
);

    localparam logic [16:0] MAX_VERTS = 17'(MAX_QUADS * 4);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PRE   = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_DWAIT = 4'd3;
    localparam logic [3:0] ST_LOC   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_EMIT  = 4'd6;
    localparam logic [3:0] ST_POST  = 4'd7;

    // Division jobs.
    localparam logic [2:0] J_OX = 3'd0;
    localparam logic [2:0] J_OY = 3'd1;
    localparam logic [2:0] J_U0 = 3'd2;
    localparam logic [2:0] J_U1 = 3'd3;
    localparam logic [2:0] J_V0 = 3'd4;
    localparam logic [2:0] J_V1 = 3'd5;

    function automatic logic signed [19:0] sat20(input logic signed [37:0] x);
        logic signed [19:0] r;
        if (x > 38'sd524287) begin
            r = 20'sd524287;
        end else if (x < -38'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = x[19:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [41:0] x);
        logic signed [23:0] r;
        if (x > 42'sd8388607) begin
            r = 24'sd8388607;
        end else if (x < -42'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

    // Control registers.
    logic [3:0]  r_state, n_state;
    logic [15:0] r_qv, n_qv;
    logic [15:0] r_cur, n_cur;
    logic        r_held, n_held;
    logic        r_ov, n_ov;
    logic [2:0]  r_dsel, n_dsel;
    logic [1:0]  r_k, n_k;
    logic [2:0]  r_m, n_m;

    // Payload registers.
    t_item              r_item, n_item;
    logic               r_pre, n_pre;
    logic               r_vert, n_vert;
    logic               r_post, n_post;
    logic signed [37:0] r_ox, n_ox;
    logic signed [37:0] r_oy, n_oy;
    logic signed [19:0] r_u [2];
    logic signed [19:0] n_u [2];
    logic signed [19:0] r_v [2];
    logic signed [19:0] n_v [2];
    logic signed [37:0] r_lx0, n_lx0, r_lx1, n_lx1;
    logic signed [37:0] r_ly0, n_ly0, r_ly1, n_ly1;
    logic signed [55:0] r_prod, n_prod;
    logic signed [57:0] r_accx, n_accx;
    logic signed [57:0] r_accy, n_accy;
    t_rec               r_orec, n_orec;

    // Helper signals.
    logic               out_free;
    logic               pre_c, vert_c, post_c;
    logic [15:0]        qv1, qv2;
    logic signed [37:0] ox_e, oy_e, sx_e, sy_e, sw_e, sh_e;
    logic signed [32:0] org_prod;
    logic signed [37:0] dv_num, dv_byp, dv_mag_s, dv_res;
    logic [15:0]        dv_den;
    logic               dv_neg, dv_bypass;
    logic               div_start, div_done;
    logic [DIV_NUM_W:0] div_quot;
    logic               c_start, c_busy;
    logic signed [17:0] c_cos, c_sin;
    logic               st_en;
    logic signed [37:0] st_val;
    logic signed [37:0] op_lx, op_ly, op_a;
    logic signed [17:0] op_b;
    logic signed [57:0] tx, ty;
    logic signed [41:0] dxe, dye, px, py;

    assign out_free = !r_ov || i_rec_ready;

    // Classify the item at the head of the queue against the batch state.
    always_comb begin
        if (i_q_item.kind == KIND_FLUSH) begin
            pre_c = (r_qv != 16'd0);
        end else begin
            pre_c = r_held && (r_cur != i_q_item.tex_id) && (r_qv != 16'd0);
        end
        vert_c = (i_q_item.kind == KIND_DRAW) && !i_q_item.tex_zero;
        qv1    = pre_c ? 16'd0 : r_qv;
        qv2    = qv1 + (vert_c ? 16'd4 : 16'd0);
        post_c = (i_q_item.kind == KIND_DRAW) && (i_imm || ({1'b0, qv2} >= MAX_VERTS))
                 && (qv2 != 16'd0);
    end

    // Operands of the current division job.
    always_comb begin
        ox_e = 38'(r_item.org_x);
        oy_e = 38'(r_item.org_y);
        sx_e = 38'(r_item.src_x);
        sy_e = 38'(r_item.src_y);
        sw_e = $signed({22'd0, r_item.src_w});
        sh_e = $signed({22'd0, r_item.src_h});
        org_prod  = '0;
        dv_byp    = '0;
        dv_bypass = 1'b0;
        case (r_dsel)
            J_OX: begin
                org_prod  = r_item.org_x * $signed({1'b0, r_item.dest_w});
                dv_num    = 38'(org_prod) <<< 4;
                dv_den    = r_item.src_w;
                dv_byp    = ox_e <<< 4;
                dv_bypass = (r_item.src_w == 16'd0);
            end
            J_OY: begin
                org_prod  = r_item.org_y * $signed({1'b0, r_item.dest_h});
                dv_num    = 38'(org_prod) <<< 4;
                dv_den    = r_item.src_h;
                dv_byp    = oy_e <<< 4;
                dv_bypass = (r_item.src_h == 16'd0);
            end
            J_U0: begin
                dv_num = sx_e <<< 16;
                dv_den = r_item.tex_w;
            end
            J_U1: begin
                dv_num = (sx_e + sw_e) <<< 16;
                dv_den = r_item.tex_w;
            end
            J_V0: begin
                dv_num = sy_e <<< 16;
                dv_den = r_item.tex_h;
            end
            default: begin
                dv_num = (sy_e + sh_e) <<< 16;
                dv_den = r_item.tex_h;
            end
        endcase
        dv_neg   = dv_num[37];
        dv_mag_s = dv_neg ? -dv_num : dv_num;
        dv_res   = dv_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    end

    // Rotation operands for the current corner and product step.
    always_comb begin
        op_lx = (r_k == 2'd1 || r_k == 2'd2) ? r_lx1 : r_lx0;
        op_ly = (r_k == 2'd2 || r_k == 2'd3) ? r_ly1 : r_ly0;
        op_a  = (r_m == 3'd0 || r_m == 3'd2) ? op_lx : op_ly;
        op_b  = (r_m == 3'd0 || r_m == 3'd3) ? c_cos : c_sin;
        tx    = r_accx + 58'sd32768;
        ty    = r_accy + 58'sd32768;
        dxe   = 42'(r_item.dest_x) <<< 8;
        dye   = 42'(r_item.dest_y) <<< 8;
        px    = $signed(tx[57:16]) + dxe;
        py    = $signed(ty[57:16]) + dye;
    end

    // Back sequencer.
    always_comb begin
        n_state  = r_state;
        n_qv     = r_qv;
        n_cur    = r_cur;
        n_held   = r_held;
        n_ov     = r_ov;
        n_dsel   = r_dsel;
        n_k      = r_k;
        n_m      = r_m;
        n_item   = r_item;
        n_pre    = r_pre;
        n_vert   = r_vert;
        n_post   = r_post;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_u      = r_u;
        n_v      = r_v;
        n_lx0    = r_lx0;
        n_lx1    = r_lx1;
        n_ly0    = r_ly0;
        n_ly1    = r_ly1;
        n_prod   = r_prod;
        n_accx   = r_accx;
        n_accy   = r_accy;
        n_orec   = r_orec;
        o_q_pop  = 1'b0;
        div_start = 1'b0;
        c_start  = 1'b0;
        st_en    = 1'b0;
        st_val   = dv_res;

        // The output register drains on its own handshake.
        if (i_rec_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_pre   = pre_c;
                    n_vert  = vert_c;
                    n_post  = post_c;
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                if (!r_pre || out_free) begin
                    if (r_pre) begin
                        n_ov           = 1'b1;
                        n_orec         = '0;
                        n_orec.rec_kind = REC_END;
                        n_orec.vtx_num = r_qv;
                        n_orec.btex    = r_cur;
                        n_orec.last    = !r_vert && !r_post;
                        n_qv           = 16'd0;
                        n_held         = 1'b0;
                        n_cur          = 16'd0;
                    end
                    if (r_item.kind == KIND_DRAW) begin
                        n_cur  = r_item.tex_id;
                        n_held = 1'b1;
                        if (r_vert) begin
                            c_start = 1'b1;
                            n_dsel  = J_OX;
                            n_state = ST_DIV;
                        end else begin
                            n_state = r_post ? ST_POST : ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (dv_bypass) begin
                    st_en  = 1'b1;
                    st_val = dv_byp;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DWAIT;
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    st_en = 1'b1;
                end
            end
            ST_LOC: begin
                n_lx0 = -r_ox;
                n_lx1 = -r_ox + $signed({14'd0, r_item.dest_w, 8'd0});
                n_ly0 = -r_oy;
                n_ly1 = -r_oy + $signed({14'd0, r_item.dest_h, 8'd0});
                if (!c_busy) begin
                    n_k     = 2'd0;
                    n_m     = 3'd0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod = op_a * op_b;
                n_m    = r_m + 1'b1;
                case (r_m)
                    3'd1:    n_accx = r_prod;
                    3'd2:    n_accx = r_accx - r_prod;
                    3'd3:    n_accy = r_prod;
                    3'd4:    n_accy = r_accy + r_prod;
                    default: ;
                endcase
                if (r_m == 3'd4) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ov            = 1'b1;
                    n_orec.rec_kind = REC_VERTEX;
                    n_orec.vtx_num  = r_qv + 16'(r_k);
                    n_orec.pos_x    = sat24(px);
                    n_orec.pos_y    = sat24(py);
                    n_orec.tex_u    = (r_k == 2'd0 || r_k == 2'd3) ? r_u[0] : r_u[1];
                    n_orec.tex_v    = (r_k == 2'd0 || r_k == 2'd1) ? r_v[0] : r_v[1];
                    n_orec.depth    = r_item.depth;
                    n_orec.color    = r_item.tint;
                    n_orec.btex     = r_cur;
                    n_orec.last     = (r_k == 2'd3) && !r_post;
                    if (r_k == 2'd3) begin
                        n_qv    = r_qv + 16'd4;
                        n_state = r_post ? ST_POST : ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_m     = 3'd0;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_POST: begin
                if (out_free) begin
                    n_ov            = 1'b1;
                    n_orec          = '0;
                    n_orec.rec_kind = REC_END;
                    n_orec.vtx_num  = r_qv;
                    n_orec.btex     = r_cur;
                    n_orec.last     = 1'b1;
                    n_qv            = 16'd0;
                    n_held          = 1'b0;
                    n_cur           = 16'd0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Store a finished division; for the texture coordinates the flip bits pick which edge it lands on.
        if (st_en) begin
            case (r_dsel)
                J_OX:    n_ox = st_val;
                J_OY:    n_oy = st_val;
                J_U0:    n_u[r_item.flip[0]] = sat20(st_val);
                J_U1:    n_u[~r_item.flip[0]] = sat20(st_val);
                J_V0:    n_v[r_item.flip[1]] = sat20(st_val);
                default: n_v[~r_item.flip[1]] = sat20(st_val);
            endcase
            if (r_dsel == J_V1) begin
                n_state = ST_LOC;
            end else begin
                n_dsel  = r_dsel + 1'b1;
                n_state = ST_DIV;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_qv    <= '0;
            r_cur   <= '0;
            r_held  <= 1'b0;
            r_ov    <= 1'b0;
            r_dsel  <= '0;
            r_k     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_qv    <= n_qv;
            r_cur   <= n_cur;
            r_held  <= n_held;
            r_ov    <= n_ov;
            r_dsel  <= n_dsel;
            r_k     <= n_k;
            r_m     <= n_m;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pre  <= n_pre;
        r_vert <= n_vert;
        r_post <= n_post;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_u    <= n_u;
        r_v    <= n_v;
        r_lx0  <= n_lx0;
        r_lx1  <= n_lx1;
        r_ly0  <= n_ly0;
        r_ly1  <= n_ly1;
        r_prod <= n_prod;
        r_accx <= n_accx;
        r_accy <= n_accy;
        r_orec <= n_orec;
    end

    assign o_rec_valid = r_ov;
    assign o_rec       = r_orec;

    // Shared divider for the origin offsets and texture coordinates.
    sqsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dv_mag_s[DIV_NUM_W-1:0]),
        .i_den   (dv_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sine and cosine, run alongside the divisions.
    sqsb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (r_item.rot),
        .o_busy  (c_busy),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

endmodule
